FILE: design/life_like_automaton_3d_generation_macros.svh
// assertion macros for the 3d life-like automaton block
`ifndef LIFE_LIKE_AUTOMATON_3D_GENERATION_MACROS_SVH
`define LIFE_LIKE_AUTOMATON_3D_GENERATION_MACROS_SVH
`ifndef SYNTHESIS
`define LLA3_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`define LLA3_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define LLA3_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define LLA3_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: design/lla3_pkg.sv
// shared constants and types for the 3d life-like automaton block
package lla3_pkg;
    localparam int SIZE_X = 32;
    localparam int SIZE_Y = 32;
    localparam int SIZE_Z = 32;
    localparam int PLANE = SIZE_X * SIZE_Y;
    localparam int LAG = PLANE + SIZE_X + 1;
    localparam int ROW_DLY = SIZE_X - 2;
    localparam int PLANE_DLY = PLANE - 2 * SIZE_X - 2;
    localparam int LINE_DEPTH = (ROW_DLY > PLANE_DLY) ? ROW_DLY : PLANE_DLY;
    localparam int LINE_AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LAG_AW = (LAG > 1) ? $clog2(LAG) : 1;
    localparam int SEEN_W = $clog2(LAG + 2);
    localparam int XW = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
    localparam int YW = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
    localparam int ZW = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
    localparam int NCELL = 9;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] REG_BIRTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURVIVAL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY = 8'd3;

    typedef logic [LINE_AW-1:0] line_addr_t;
    typedef logic [2:0] taps_t;
endpackage

FILE: design/lla3_ram.sv
// generic single-port-write ram with registered read
module lla3_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: design/lla3_cell.sv
// one window row: line delay followed by three taps
module lla3_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift,
    input  logic                use_delay,
    input  lla3_pkg::line_addr_t len_m1,
    input  logic                din,
    output lla3_pkg::taps_t     taps,
    output logic                fwd
);
    import lla3_pkg::*;

    line_addr_t ptr_reg;
    line_addr_t ptr_next;
    logic       q;
    logic       t0_reg;
    logic       t1_reg;
    logic       t2_reg;
    logic       t0;

    lla3_ram #(.WIDTH(1), .DEPTH(LINE_DEPTH)) u_line (
        .aclk  (aclk),
        .we    (shift & use_delay),
        .waddr (ptr_reg),
        .wdata (din),
        .re    (shift & use_delay),
        .raddr (ptr_reg),
        .rdata (q)
    );

    assign ptr_next = (ptr_reg == len_m1) ? '0 : ptr_reg + 1'b1;
    assign t0 = use_delay ? q : t0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (shift) begin
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            t0_reg <= din;
            t1_reg <= t0;
            t2_reg <= t1_reg;
        end
    end

    assign taps = {t2_reg, t1_reg, t0};
    assign fwd = t1_reg;
endmodule

FILE: design/life_like_automaton_3d_generation.sv
// top level of the 3d life-like automaton generation block
// cells enter on the s_ channel in raster order (x fastest, then y, then z),
// one transaction per cycle while s_tready is high; s_tuser marks a filler (flush) cell.
// results leave on the m_ channel, one per centre cell, tlast on the final
// cell of the volume. the first SIZE_X*SIZE_Y+SIZE_X+1 transactions of a
// volume only fill the window; after that each input gives one result, so
// after the volume that many fillers flush the last results.
// each result passes the window stage and then the output register before it
// appears on m_; while s_tready is high the block sustains one cell per cycle:
// nine row cells hold the 3x3x3 window, joined by line delays in ram, and the
// centre decay bit runs through a ram delay of the same lag.
// when the receiver stalls, one result waits in the output register and one
// more in the window stage; s_tready then drops until m_tready returns.
// reset (aresetn low, synchronous) restarts priming and loads the default
// registers: empty masks, all 26 neighbours enabled, decay off.
// registers are written on the cfg_ channel: index 0 birth mask, 1 survival
// mask, 2 neighbour enable, 3 decay enable; other indexes are ignored.
`include "life_like_automaton_3d_generation_macros.svh"
module life_like_automaton_3d_generation (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // cell_alive, cell_decaying
    input  logic                                s_tuser,   // filler
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // next_alive, neighbour_count[4:0]
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lla3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lla3_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lla3_pkg::*;

    logic [26:0]       birth_reg;
    logic [26:0]       surv_reg;
    logic [25:0]       en_reg;
    logic              decay_en_reg;

    logic              shift;
    logic              alive_in;
    logic              dec_in;
    logic              produce;
    logic              out_free;
    logic              load;

    logic [SEEN_W-1:0] seen_reg;
    logic [XW-1:0]     ix_reg;
    logic [YW-1:0]     iy_reg;
    logic [ZW-1:0]     iz_reg;
    logic [XW-1:0]     wx_reg;
    logic [YW-1:0]     wy_reg;
    logic [ZW-1:0]     wz_reg;
    logic              wlast_reg;
    logic              pend_reg;
    logic              issue_last;

    logic [LAG_AW-1:0] dptr_reg;
    logic              dec_q;

    taps_t             taps [NCELL];
    logic              fwd [NCELL];

    logic [25:0]       nb;
    logic [4:0]        count;
    logic              next_alive;

    logic [5:0]        mdata_reg;
    logic              mlast_reg;
    logic              mvalid_reg;

    assign cfg_ready = 1'b1;
    assign shift = s_tvalid & s_tready;
    assign alive_in = s_tdata[0] & ~s_tuser;
    assign dec_in = s_tdata[1] & ~s_tuser;
    assign produce = (seen_reg >= SEEN_W'(LAG));
    assign out_free = !mvalid_reg || m_tready;
    assign load = pend_reg && out_free;
    assign s_tready = !pend_reg || out_free;
    assign issue_last = (ix_reg == XW'(SIZE_X - 1)) && (iy_reg == YW'(SIZE_Y - 1)) &&
                        (iz_reg == ZW'(SIZE_Z - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            birth_reg <= '0;
            surv_reg <= '0;
            en_reg <= '1;
            decay_en_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BIRTH:     birth_reg <= cfg_data;
                REG_SURVIVAL:  surv_reg <= cfg_data;
                REG_NEIGHBOUR: en_reg <= cfg_data[25:0];
                REG_DECAY:     decay_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++) begin : g_cell
            localparam int LEN = ((gi % 3) == 0) ? PLANE_DLY : ROW_DLY;
            lla3_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift     (shift),
                .use_delay ((gi != 0) ? 1'b1 : 1'b0),
                .len_m1    (LINE_AW'(LEN - 1)),
                .din       ((gi == 0) ? alive_in : fwd[(gi == 0) ? 0 : gi - 1]),
                .taps      (taps[gi]),
                .fwd       (fwd[gi])
            );
        end
    endgenerate

    lla3_ram #(.WIDTH(1), .DEPTH(LAG)) u_decay (
        .aclk  (aclk),
        .we    (shift),
        .waddr (dptr_reg),
        .wdata (dec_in),
        .re    (shift),
        .raddr (dptr_reg),
        .rdata (dec_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dptr_reg <= '0;
            seen_reg <= '0;
            ix_reg <= '0;
            iy_reg <= '0;
            iz_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (shift) begin
                dptr_reg <= (dptr_reg == LAG_AW'(LAG - 1)) ? '0 : dptr_reg + 1'b1;
                if (produce && issue_last) begin
                    seen_reg <= '0;
                    ix_reg <= '0;
                    iy_reg <= '0;
                    iz_reg <= '0;
                end else begin
                    if (seen_reg <= SEEN_W'(LAG)) begin
                        seen_reg <= seen_reg + 1'b1;
                    end
                    if (produce) begin
                        if (ix_reg == XW'(SIZE_X - 1)) begin
                            ix_reg <= '0;
                            if (iy_reg == YW'(SIZE_Y - 1)) begin
                                iy_reg <= '0;
                                iz_reg <= iz_reg + 1'b1;
                            end else begin
                                iy_reg <= iy_reg + 1'b1;
                            end
                        end else begin
                            ix_reg <= ix_reg + 1'b1;
                        end
                    end
                end
            end
            if (shift && produce) begin
                pend_reg <= 1'b1;
            end else if (load) begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift && produce) begin
            wx_reg <= ix_reg;
            wy_reg <= iy_reg;
            wz_reg <= iz_reg;
            wlast_reg <= issue_last;
        end
    end

    always_comb begin
        int dx;
        int dy;
        int dz;
        int bi;
        int ci;
        logic xok;
        logic yok;
        logic zok;
        nb = '0;
        for (int k = 0; k < 27; k++) begin
            dx = (k % 3) - 1;
            dy = ((k / 3) % 3) - 1;
            dz = (k / 9) - 1;
            bi = (k < 13) ? k : k - 1;
            ci = 3 * (1 - dz) + (1 - dy);
            xok = (dx == 0) || ((dx < 0) ? (wx_reg != '0) : (wx_reg != XW'(SIZE_X - 1)));
            yok = (dy == 0) || ((dy < 0) ? (wy_reg != '0) : (wy_reg != YW'(SIZE_Y - 1)));
            zok = (dz == 0) || ((dz < 0) ? (wz_reg != '0) : (wz_reg != ZW'(SIZE_Z - 1)));
            if (k != 13) begin
                nb[bi] = taps[ci][1 - dx] & en_reg[bi] & xok & yok & zok;
            end
        end
    end

    assign count = 5'($countones(nb));

    always_comb begin
        if (taps[4][1]) begin
            next_alive = surv_reg[count];
        end else if (decay_en_reg && dec_q) begin
            next_alive = 1'b0;
        end else begin
            next_alive = birth_reg[count];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (load) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mdata_reg <= {count, next_alive};
            mlast_reg <= wlast_reg;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata = {2'b00, mdata_reg};
    assign m_tlast = mlast_reg;

    `LLA3_ASSERT_NEXT(a_pend_holds, aclk, aresetn, pend_reg && !out_free, pend_reg)
    `LLA3_ASSERT_NOW(a_stall_has_pend, aclk, aresetn, !s_tready, pend_reg && mvalid_reg)
    `LLA3_ASSERT_NOW(a_count_range, aclk, aresetn, mvalid_reg, mdata_reg[5:1] <= 5'd26)
endmodule
